// ===== hw/rtl/i2cee_pkg.sv =====
// ============================================================================
// i2cee_pkg
// Types and codes shared by the I2C EEPROM access sequencer modules.
// ============================================================================
package i2cee_pkg;

    // Actions carried by an input transfer.
    localparam logic [1:0] ACT_WRITE = 2'd0;
    localparam logic [1:0] ACT_READ  = 2'd1;
    localparam logic [1:0] ACT_EVENT = 2'd2;

    // Chip numbers that a request may select.
    localparam logic [1:0] CHIP_ONE = 2'd1;
    localparam logic [1:0] CHIP_TWO = 2'd2;

    // Configuration register indexes.
    localparam logic CFG_CHIP_ONE_PINS = 1'b0;
    localparam logic CFG_CHIP_TWO_PINS = 1'b1;

    // Reset values of the configuration registers.
    localparam logic [2:0] CHIP_ONE_PINS_RESET = 3'd2;
    localparam logic [2:0] CHIP_TWO_PINS_RESET = 3'd3;

    // Engine status codes, low three bits cleared.
    localparam logic [7:0] STATUS_MASK     = 8'hF8;
    localparam logic [7:0] ST_START        = 8'h08;
    localparam logic [7:0] ST_REP_START    = 8'h10;
    localparam logic [7:0] ST_SLAW_ACK     = 8'h18;
    localparam logic [7:0] ST_DATA_TX_ACK  = 8'h28;
    localparam logic [7:0] ST_SLAR_ACK     = 8'h40;
    localparam logic [7:0] ST_DATA_RX_NACK = 8'h58;

    // Slave address byte: device type code with the read flag in bit 0.
    localparam logic [7:0] SLA_BASE     = 8'hA0;
    localparam logic [7:0] SLA_READ_BIT = 8'h01;

    typedef enum logic [2:0] {
        CMD_NONE  = 3'd0,
        CMD_START = 3'd1,
        CMD_SEND  = 3'd2,
        CMD_RECV  = 3'd3,
        CMD_STOP  = 3'd4
    } cmd_t;

    typedef enum logic [2:0] {
        ERR_OK        = 3'd0,
        ERR_BAD_CHIP  = 3'd1,
        ERR_START     = 3'd2,
        ERR_ADDR_NACK = 3'd3,
        ERR_DATA_NACK = 3'd4,
        ERR_RESTART   = 3'd5,
        ERR_READ_SEL  = 3'd6,
        ERR_READ_DATA = 3'd7
    } err_t;

    typedef enum logic [3:0] {
        PH_IDLE    = 4'd0,
        PH_START   = 4'd1,
        PH_SLAW    = 4'd2,
        PH_ADDRH   = 4'd3,
        PH_ADDRL   = 4'd4,
        PH_DATA    = 4'd5,
        PH_RESTART = 4'd6,
        PH_SLAR    = 4'd7,
        PH_RX      = 4'd8
    } phase_t;

    typedef struct packed {
        logic [1:0]  action;
        logic [1:0]  chip;
        logic [15:0] mem_address;
        logic [7:0]  write_byte;
        logic [7:0]  bus_status;
        logic [7:0]  rx_byte;
    } item_t;

    typedef struct packed {
        cmd_t       command;
        logic [7:0] tx_byte;
        logic       done_res;
        err_t       error_code;
        logic [7:0] read_byte;
    } result_t;

endpackage

// ===== hw/rtl/i2cee_in_stage.sv =====
// ============================================================================
// i2cee_in_stage
// Input register: holds one accepted transfer until the sequencer takes it.
// ============================================================================
module i2cee_in_stage (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  i2cee_pkg::item_t   item,
    input  logic               take,
    output logic               held_valid,
    output i2cee_pkg::item_t   held_item
);

    logic             valid_reg;
    logic             valid_next;
    i2cee_pkg::item_t item_reg;
    logic             accept;

    // The register frees up in the same cycle that its contents are taken.
    assign in_stall   = valid_reg && !take;
    assign accept     = in_valid && !in_stall;
    assign held_valid = valid_reg;
    assign held_item  = item_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (accept)
        begin
            valid_next = 1'b1;
        end
        else if (take)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg <= item;
        end
    end

endmodule

// ===== hw/rtl/i2cee_ctrl.sv =====
// ============================================================================
// i2cee_ctrl
// Transaction state machine: checks each engine status and picks the next
// engine command, one input transfer per cycle in which fire is high.
// ============================================================================
module i2cee_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               fire,
    input  i2cee_pkg::item_t   item,
    input  logic [2:0]         chip_one_pins,
    input  logic [2:0]         chip_two_pins,
    output logic               res_valid,
    output i2cee_pkg::result_t res
);

    i2cee_pkg::phase_t phase_reg;
    i2cee_pkg::phase_t phase_next;
    logic              is_read_reg;
    logic              is_read_next;
    logic [2:0]        pins_reg;
    logic [2:0]        pins_next;
    logic [15:0]       address_reg;
    logic [15:0]       address_next;
    logic [7:0]        data_reg;
    logic [7:0]        data_next;

    logic              is_request;
    logic              is_event;
    logic              chip_ok;
    logic [2:0]        chip_pins;
    logic [7:0]        st;
    logic [7:0]        sla_w;

    assign is_request = (item.action == i2cee_pkg::ACT_WRITE)
                     || (item.action == i2cee_pkg::ACT_READ);
    assign is_event   = (item.action == i2cee_pkg::ACT_EVENT);
    assign chip_ok    = (item.chip == i2cee_pkg::CHIP_ONE)
                     || (item.chip == i2cee_pkg::CHIP_TWO);
    assign chip_pins  = (item.chip == i2cee_pkg::CHIP_ONE) ? chip_one_pins : chip_two_pins;
    assign st         = item.bus_status & i2cee_pkg::STATUS_MASK;
    assign sla_w      = i2cee_pkg::SLA_BASE | {4'b0000, pins_reg, 1'b0};

    // Next state.
    always_comb
    begin
        phase_next   = phase_reg;
        is_read_next = is_read_reg;
        pins_next    = pins_reg;
        address_next = address_reg;
        data_next    = data_reg;
        if (fire && is_request)
        begin
            if (phase_reg == i2cee_pkg::PH_IDLE && chip_ok)
            begin
                phase_next   = i2cee_pkg::PH_START;
                is_read_next = (item.action == i2cee_pkg::ACT_READ);
                pins_next    = chip_pins;
                address_next = item.mem_address;
                data_next    = item.write_byte;
            end
        end
        else if (fire && is_event)
        begin
            unique case (phase_reg)
                i2cee_pkg::PH_IDLE:
                begin
                    phase_next = i2cee_pkg::PH_IDLE;
                end
                i2cee_pkg::PH_START:
                begin
                    phase_next = (st == i2cee_pkg::ST_START || st == i2cee_pkg::ST_REP_START)
                               ? i2cee_pkg::PH_SLAW : i2cee_pkg::PH_IDLE;
                end
                i2cee_pkg::PH_SLAW:
                begin
                    // A NACK on the slave address retries the start.
                    phase_next = (st == i2cee_pkg::ST_SLAW_ACK)
                               ? i2cee_pkg::PH_ADDRH : i2cee_pkg::PH_START;
                end
                i2cee_pkg::PH_ADDRH:
                begin
                    phase_next = (st == i2cee_pkg::ST_DATA_TX_ACK)
                               ? i2cee_pkg::PH_ADDRL : i2cee_pkg::PH_IDLE;
                end
                i2cee_pkg::PH_ADDRL:
                begin
                    if (st != i2cee_pkg::ST_DATA_TX_ACK)
                    begin
                        phase_next = i2cee_pkg::PH_IDLE;
                    end
                    else if (is_read_reg)
                    begin
                        phase_next = i2cee_pkg::PH_RESTART;
                    end
                    else
                    begin
                        phase_next = i2cee_pkg::PH_DATA;
                    end
                end
                i2cee_pkg::PH_RESTART:
                begin
                    phase_next = (st == i2cee_pkg::ST_REP_START)
                               ? i2cee_pkg::PH_SLAR : i2cee_pkg::PH_IDLE;
                end
                i2cee_pkg::PH_SLAR:
                begin
                    phase_next = (st == i2cee_pkg::ST_SLAR_ACK)
                               ? i2cee_pkg::PH_RX : i2cee_pkg::PH_IDLE;
                end
                default:
                begin
                    phase_next = i2cee_pkg::PH_IDLE;
                end
            endcase
        end
    end

    // Result of the current transfer.
    always_comb
    begin
        res_valid      = 1'b0;
        res.command    = i2cee_pkg::CMD_NONE;
        res.tx_byte    = 8'h00;
        res.done_res   = 1'b0;
        res.error_code = i2cee_pkg::ERR_OK;
        res.read_byte  = 8'h00;
        if (is_request)
        begin
            if (phase_reg == i2cee_pkg::PH_IDLE)
            begin
                res_valid = 1'b1;
                if (chip_ok)
                begin
                    res.command = i2cee_pkg::CMD_START;
                end
                else
                begin
                    res.done_res   = 1'b1;
                    res.error_code = i2cee_pkg::ERR_BAD_CHIP;
                end
            end
        end
        else if (is_event)
        begin
            unique case (phase_reg)
                i2cee_pkg::PH_IDLE:
                begin
                    res_valid = 1'b0;
                end
                i2cee_pkg::PH_START:
                begin
                    res_valid = 1'b1;
                    if (st == i2cee_pkg::ST_START || st == i2cee_pkg::ST_REP_START)
                    begin
                        res.command = i2cee_pkg::CMD_SEND;
                        res.tx_byte = sla_w;
                    end
                    else
                    begin
                        res.done_res   = 1'b1;
                        res.error_code = i2cee_pkg::ERR_START;
                    end
                end
                i2cee_pkg::PH_SLAW:
                begin
                    res_valid = 1'b1;
                    if (st == i2cee_pkg::ST_SLAW_ACK)
                    begin
                        res.command = i2cee_pkg::CMD_SEND;
                        res.tx_byte = address_reg[15:8];
                    end
                    else
                    begin
                        res.command = i2cee_pkg::CMD_START;
                    end
                end
                i2cee_pkg::PH_ADDRH:
                begin
                    res_valid = 1'b1;
                    if (st == i2cee_pkg::ST_DATA_TX_ACK)
                    begin
                        res.command = i2cee_pkg::CMD_SEND;
                        res.tx_byte = address_reg[7:0];
                    end
                    else
                    begin
                        res.done_res   = 1'b1;
                        res.error_code = i2cee_pkg::ERR_ADDR_NACK;
                    end
                end
                i2cee_pkg::PH_ADDRL:
                begin
                    res_valid = 1'b1;
                    if (st != i2cee_pkg::ST_DATA_TX_ACK)
                    begin
                        res.done_res   = 1'b1;
                        res.error_code = i2cee_pkg::ERR_ADDR_NACK;
                    end
                    else if (is_read_reg)
                    begin
                        res.command = i2cee_pkg::CMD_START;
                    end
                    else
                    begin
                        res.command = i2cee_pkg::CMD_SEND;
                        res.tx_byte = data_reg;
                    end
                end
                i2cee_pkg::PH_DATA:
                begin
                    res_valid    = 1'b1;
                    res.done_res = 1'b1;
                    if (st == i2cee_pkg::ST_DATA_TX_ACK)
                    begin
                        res.command = i2cee_pkg::CMD_STOP;
                    end
                    else
                    begin
                        res.error_code = i2cee_pkg::ERR_DATA_NACK;
                    end
                end
                i2cee_pkg::PH_RESTART:
                begin
                    res_valid = 1'b1;
                    if (st == i2cee_pkg::ST_REP_START)
                    begin
                        res.command = i2cee_pkg::CMD_SEND;
                        res.tx_byte = sla_w | i2cee_pkg::SLA_READ_BIT;
                    end
                    else
                    begin
                        res.done_res   = 1'b1;
                        res.error_code = i2cee_pkg::ERR_RESTART;
                    end
                end
                i2cee_pkg::PH_SLAR:
                begin
                    res_valid = 1'b1;
                    if (st == i2cee_pkg::ST_SLAR_ACK)
                    begin
                        res.command = i2cee_pkg::CMD_RECV;
                    end
                    else
                    begin
                        res.done_res   = 1'b1;
                        res.error_code = i2cee_pkg::ERR_READ_SEL;
                    end
                end
                i2cee_pkg::PH_RX:
                begin
                    res_valid    = 1'b1;
                    res.done_res = 1'b1;
                    if (st == i2cee_pkg::ST_DATA_RX_NACK)
                    begin
                        res.command   = i2cee_pkg::CMD_STOP;
                        res.read_byte = item.rx_byte;
                    end
                    else
                    begin
                        res.error_code = i2cee_pkg::ERR_READ_DATA;
                    end
                end
                default:
                begin
                    res_valid = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= i2cee_pkg::PH_IDLE;
            is_read_reg <= 1'b0;
            pins_reg    <= 3'd0;
            address_reg <= 16'h0000;
            data_reg    <= 8'h00;
        end
        else
        begin
            phase_reg   <= phase_next;
            is_read_reg <= is_read_next;
            pins_reg    <= pins_next;
            address_reg <= address_next;
            data_reg    <= data_next;
        end
    end

`ifndef SYNTHESIS
    // A request taken while idle with a valid chip always moves to the start phase.
    assert property (@(posedge clk) disable iff (!rst_n)
        fire && is_request && chip_ok && phase_reg == i2cee_pkg::PH_IDLE
        |=> phase_reg == i2cee_pkg::PH_START)
        else $error("request did not open a transaction");

    // Every finished operation leaves the state machine idle.
    assert property (@(posedge clk) disable iff (!rst_n)
        fire && res_valid && res.done_res |=> phase_reg == i2cee_pkg::PH_IDLE)
        else $error("state machine busy after a finished operation");

    // A request while busy leaves the transaction untouched.
    assert property (@(posedge clk) disable iff (!rst_n)
        fire && is_request && phase_reg != i2cee_pkg::PH_IDLE
        |=> $stable(phase_reg) && $stable(address_reg))
        else $error("request disturbed a running transaction");
`endif

endmodule

// ===== hw/rtl/i2c_eeprom_access_sequencer.sv =====
// ============================================================================
// i2c_eeprom_access_sequencer
// Master-side sequencer for one-byte random writes and reads on a
// two-byte-addressed I2C EEPROM, driving a byte-level I2C engine.
// ============================================================================
// The block takes one input transfer in every cycle while the output is not
// stalled, and answers it with at most one command transfer. An input passes
// through an input register, the state machine logic and an output register.
// The state machine handles each transfer as it fires, so the block can take
// a new transfer before the last result has left the output register. While
// the output register holds a result that is stalled, the input register
// keeps one more transfer. The chip pin registers are written through the
// configuration port and should only change while no transaction is running.
module i2c_eeprom_access_sequencer (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wr_en,
    input  logic        cfg_index,
    input  logic [2:0]  cfg_data,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  action,
    input  logic [1:0]  chip,
    input  logic [15:0] mem_address,
    input  logic [7:0]  write_byte,
    input  logic [7:0]  bus_status,
    input  logic [7:0]  rx_byte,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [2:0]  command,
    output logic [7:0]  tx_byte,
    output logic        done_res,
    output logic [2:0]  error_code,
    output logic [7:0]  read_byte
);

    logic [2:0]         chip_one_pins_reg;
    logic [2:0]         chip_two_pins_reg;
    i2cee_pkg::item_t   in_item;
    i2cee_pkg::item_t   held_item;
    logic               held_valid;
    logic               fire;
    logic               res_valid;
    i2cee_pkg::result_t res;
    logic               out_valid_reg;
    logic               out_valid_next;
    i2cee_pkg::result_t out_reg;

    assign in_item.action      = action;
    assign in_item.chip        = chip;
    assign in_item.mem_address = mem_address;
    assign in_item.write_byte  = write_byte;
    assign in_item.bus_status  = bus_status;
    assign in_item.rx_byte     = rx_byte;

    // The held transfer is processed once the output register has room.
    assign fire = held_valid && (!out_valid_reg || !out_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            chip_one_pins_reg <= i2cee_pkg::CHIP_ONE_PINS_RESET;
            chip_two_pins_reg <= i2cee_pkg::CHIP_TWO_PINS_RESET;
        end
        else if (cfg_wr_en)
        begin
            if (cfg_index == i2cee_pkg::CFG_CHIP_ONE_PINS)
            begin
                chip_one_pins_reg <= cfg_data;
            end
            else
            begin
                chip_two_pins_reg <= cfg_data;
            end
        end
    end

    i2cee_in_stage u_in_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .item       (in_item),
        .take       (fire),
        .held_valid (held_valid),
        .held_item  (held_item)
    );

    i2cee_ctrl u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .fire          (fire),
        .item          (held_item),
        .chip_one_pins (chip_one_pins_reg),
        .chip_two_pins (chip_two_pins_reg),
        .res_valid     (res_valid),
        .res           (res)
    );

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (fire)
        begin
            out_valid_next = res_valid;
        end
        else if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire && res_valid)
        begin
            out_reg <= res;
        end
    end

    assign out_valid  = out_valid_reg;
    assign command    = out_reg.command;
    assign tx_byte    = out_reg.tx_byte;
    assign done_res   = out_reg.done_res;
    assign error_code = out_reg.error_code;
    assign read_byte  = out_reg.read_byte;

`ifndef SYNTHESIS
    // A finished operation ends either with a stop or with no command at all.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && done_res
        |-> command == i2cee_pkg::CMD_STOP || command == i2cee_pkg::CMD_NONE)
        else $error("finished operation carries a bus command");

    // An error is only reported on a finished operation, without a command.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && error_code != i2cee_pkg::ERR_OK
        |-> done_res && command == i2cee_pkg::CMD_NONE)
        else $error("error reported on an unfinished operation");

    // A byte to send only accompanies a send command.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && tx_byte != 8'h00 |-> command == i2cee_pkg::CMD_SEND)
        else $error("transmit byte without a send command");

    // A held result that is stalled blocks the state machine.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_stall |-> !fire)
        else $error("state machine stepped over a stalled result");
`endif

endmodule

// ===== verif/tb.sv =====
`timescale 1ns / 1ps
// ============================================================================
// tb
// Self-checking bench for the I2C EEPROM access sequencer. Requests and
// engine status events are sent over the input channel with random gaps.
// The output channel is stalled at random. A predictor written from the
// protocol rules compares every command transfer field by field, in order.
// ============================================================================
module tb;

    localparam int unsigned WATCHDOG_LIMIT = 600;
    localparam int unsigned SETTLE_CYCLES  = 8;
    localparam int unsigned MAX_REPORTS    = 10;

    logic        clk         = 1'b0;
    logic        rst_n       = 1'b0;
    logic        cfg_wr_en   = 1'b0;
    logic        cfg_index   = 1'b0;
    logic [2:0]  cfg_data    = 3'd0;
    logic        in_valid    = 1'b0;
    logic        in_stall;
    logic [1:0]  action      = 2'd0;
    logic [1:0]  chip        = 2'd0;
    logic [15:0] mem_address = 16'd0;
    logic [7:0]  write_byte  = 8'd0;
    logic [7:0]  bus_status  = 8'd0;
    logic [7:0]  rx_byte     = 8'd0;
    logic        out_valid;
    logic        out_stall   = 1'b0;
    logic [2:0]  command;
    logic [7:0]  tx_byte;
    logic        done_res;
    logic [2:0]  error_code;
    logic [7:0]  read_byte;

    // Predicted state of the sequencer and its pin registers.
    i2cee_pkg::phase_t pred_phase;
    logic              pred_is_read;
    logic [2:0]        pred_pins;
    logic [15:0]       pred_address;
    logic [7:0]        pred_data;
    logic [2:0]        pred_pins_one;
    logic [2:0]        pred_pins_two;

    i2cee_pkg::result_t expected_cmds[$];
    int unsigned mismatches     = 0;
    int unsigned answered_items = 0;
    bit          sender_idles   = 1'b1;
    bit          receiver_idles = 1'b1;
    int unsigned stall_left     = 0;

    i2c_eeprom_access_sequencer dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .action      (action),
        .chip        (chip),
        .mem_address (mem_address),
        .write_byte  (write_byte),
        .bus_status  (bus_status),
        .rx_byte     (rx_byte),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .command     (command),
        .tx_byte     (tx_byte),
        .done_res    (done_res),
        .error_code  (error_code),
        .read_byte   (read_byte)
    );

    initial
    begin
        forever #4 clk = ~clk;
    end

    // ------------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------------
    function automatic void issue(input i2cee_pkg::cmd_t cmd, input logic [7:0] tx,
                                  input logic done, input i2cee_pkg::err_t err,
                                  input logic [7:0] rd);
        i2cee_pkg::result_t r;
        r.command    = cmd;
        r.tx_byte    = tx;
        r.done_res   = done;
        r.error_code = err;
        r.read_byte  = rd;
        expected_cmds.push_back(r);
    endfunction

    function automatic void abort_with(input i2cee_pkg::err_t err);
        pred_phase = i2cee_pkg::PH_IDLE;
        issue(i2cee_pkg::CMD_NONE, 8'h00, 1'b1, err, 8'h00);
    endfunction

    // Advances the predicted sequencer by one accepted transfer; returns 1 when
    // the transfer is answered with a command transfer.
    function automatic bit advance_sequencer(input i2cee_pkg::item_t it);
        logic [7:0] st;
        logic [7:0] sla_w;
        st    = it.bus_status & i2cee_pkg::STATUS_MASK;
        sla_w = i2cee_pkg::SLA_BASE | {4'b0000, pred_pins, 1'b0};
        if (it.action == i2cee_pkg::ACT_WRITE || it.action == i2cee_pkg::ACT_READ)
        begin
            if (pred_phase != i2cee_pkg::PH_IDLE)
                return 1'b0;
            if (it.chip == i2cee_pkg::CHIP_ONE)
                pred_pins = pred_pins_one;
            else if (it.chip == i2cee_pkg::CHIP_TWO)
                pred_pins = pred_pins_two;
            else
            begin
                abort_with(i2cee_pkg::ERR_BAD_CHIP);
                return 1'b1;
            end
            pred_is_read = (it.action == i2cee_pkg::ACT_READ);
            pred_address = it.mem_address;
            pred_data    = it.write_byte;
            pred_phase   = i2cee_pkg::PH_START;
            issue(i2cee_pkg::CMD_START, 8'h00, 1'b0, i2cee_pkg::ERR_OK, 8'h00);
            return 1'b1;
        end
        if (it.action != i2cee_pkg::ACT_EVENT)
            return 1'b0;
        case (pred_phase)
            i2cee_pkg::PH_START:
            begin
                if (st != i2cee_pkg::ST_START && st != i2cee_pkg::ST_REP_START)
                    abort_with(i2cee_pkg::ERR_START);
                else
                begin
                    pred_phase = i2cee_pkg::PH_SLAW;
                    issue(i2cee_pkg::CMD_SEND, sla_w, 1'b0, i2cee_pkg::ERR_OK, 8'h00);
                end
            end
            i2cee_pkg::PH_SLAW:
            begin
                // A NACK on the write address means the chip is busy: poll again.
                if (st != i2cee_pkg::ST_SLAW_ACK)
                begin
                    pred_phase = i2cee_pkg::PH_START;
                    issue(i2cee_pkg::CMD_START, 8'h00, 1'b0, i2cee_pkg::ERR_OK, 8'h00);
                end
                else
                begin
                    pred_phase = i2cee_pkg::PH_ADDRH;
                    issue(i2cee_pkg::CMD_SEND, pred_address[15:8], 1'b0,
                          i2cee_pkg::ERR_OK, 8'h00);
                end
            end
            i2cee_pkg::PH_ADDRH:
            begin
                if (st != i2cee_pkg::ST_DATA_TX_ACK)
                    abort_with(i2cee_pkg::ERR_ADDR_NACK);
                else
                begin
                    pred_phase = i2cee_pkg::PH_ADDRL;
                    issue(i2cee_pkg::CMD_SEND, pred_address[7:0], 1'b0,
                          i2cee_pkg::ERR_OK, 8'h00);
                end
            end
            i2cee_pkg::PH_ADDRL:
            begin
                if (st != i2cee_pkg::ST_DATA_TX_ACK)
                    abort_with(i2cee_pkg::ERR_ADDR_NACK);
                else if (pred_is_read)
                begin
                    pred_phase = i2cee_pkg::PH_RESTART;
                    issue(i2cee_pkg::CMD_START, 8'h00, 1'b0, i2cee_pkg::ERR_OK, 8'h00);
                end
                else
                begin
                    pred_phase = i2cee_pkg::PH_DATA;
                    issue(i2cee_pkg::CMD_SEND, pred_data, 1'b0, i2cee_pkg::ERR_OK, 8'h00);
                end
            end
            i2cee_pkg::PH_DATA:
            begin
                if (st != i2cee_pkg::ST_DATA_TX_ACK)
                    abort_with(i2cee_pkg::ERR_DATA_NACK);
                else
                begin
                    pred_phase = i2cee_pkg::PH_IDLE;
                    issue(i2cee_pkg::CMD_STOP, 8'h00, 1'b1, i2cee_pkg::ERR_OK, 8'h00);
                end
            end
            i2cee_pkg::PH_RESTART:
            begin
                if (st != i2cee_pkg::ST_REP_START)
                    abort_with(i2cee_pkg::ERR_RESTART);
                else
                begin
                    pred_phase = i2cee_pkg::PH_SLAR;
                    issue(i2cee_pkg::CMD_SEND, sla_w | i2cee_pkg::SLA_READ_BIT, 1'b0,
                          i2cee_pkg::ERR_OK, 8'h00);
                end
            end
            i2cee_pkg::PH_SLAR:
            begin
                if (st != i2cee_pkg::ST_SLAR_ACK)
                    abort_with(i2cee_pkg::ERR_READ_SEL);
                else
                begin
                    pred_phase = i2cee_pkg::PH_RX;
                    issue(i2cee_pkg::CMD_RECV, 8'h00, 1'b0, i2cee_pkg::ERR_OK, 8'h00);
                end
            end
            i2cee_pkg::PH_RX:
            begin
                if (st != i2cee_pkg::ST_DATA_RX_NACK)
                    abort_with(i2cee_pkg::ERR_READ_DATA);
                else
                begin
                    pred_phase = i2cee_pkg::PH_IDLE;
                    issue(i2cee_pkg::CMD_STOP, 8'h00, 1'b1, i2cee_pkg::ERR_OK, it.rx_byte);
                end
            end
            i2cee_pkg::PH_IDLE:
                return 1'b0;
            default:
            begin
                pred_phase = i2cee_pkg::PH_IDLE;
                return 1'b0;
            end
        endcase
        return 1'b1;
    endfunction

    // ------------------------------------------------------------------------
    // Channel drivers
    // ------------------------------------------------------------------------
    task automatic hold_off(input int unsigned cycles);
        repeat (cycles)
        begin
            @(negedge clk);
            in_valid <= 1'b0;
        end
    endtask

    task automatic send_item(input i2cee_pkg::item_t it);
        if (sender_idles && $urandom_range(0, 9) == 0)
            hold_off($urandom_range(1, 19));
        @(negedge clk);
        in_valid    <= 1'b1;
        action      <= it.action;
        chip        <= it.chip;
        mem_address <= it.mem_address;
        write_byte  <= it.write_byte;
        bus_status  <= it.bus_status;
        rx_byte     <= it.rx_byte;
        do
            @(posedge clk);
        while (in_stall);
        if (advance_sequencer(it))
            answered_items++;
    endtask

    task automatic send_request(input logic [1:0] act, input logic [1:0] chip_no,
                                input logic [15:0] addr, input logic [7:0] data);
        i2cee_pkg::item_t it;
        it.action      = act;
        it.chip        = chip_no;
        it.mem_address = addr;
        it.write_byte  = data;
        it.bus_status  = 8'($urandom);
        it.rx_byte     = 8'($urandom);
        send_item(it);
    endtask

    task automatic send_event(input logic [7:0] status, input logic [7:0] rx);
        i2cee_pkg::item_t it;
        it.action      = i2cee_pkg::ACT_EVENT;
        it.chip        = 2'($urandom);
        it.mem_address = 16'($urandom);
        it.write_byte  = 8'($urandom);
        it.bus_status  = status;
        it.rx_byte     = rx;
        send_item(it);
    endtask

    // Waits until every expected transfer has arrived and anything ignored
    // has drained out of the pipeline.
    task automatic settle();
        @(negedge clk);
        in_valid <= 1'b0;
        wait (expected_cmds.size() == 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_pins(input logic index, input logic [2:0] value);
        settle();
        @(negedge clk);
        cfg_wr_en <= 1'b1;
        cfg_index <= index;
        cfg_data  <= value;
        if (index == i2cee_pkg::CFG_CHIP_ONE_PINS)
            pred_pins_one = value;
        else
            pred_pins_two = value;
        @(negedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    always @(negedge clk)
    begin
        if (stall_left > 0)
        begin
            stall_left--;
            out_stall <= 1'b1;
        end
        else if (receiver_idles && $urandom_range(0, 11) == 0)
        begin
            stall_left = $urandom_range(1, 19) - 1;
            out_stall <= 1'b1;
        end
        else
            out_stall <= 1'b0;
    end

    // ------------------------------------------------------------------------
    // Checking
    // ------------------------------------------------------------------------
    task automatic flag_mismatch(input string what, input int unsigned want,
                                 input int unsigned got);
        mismatches++;
        if (mismatches <= MAX_REPORTS)
            $display("%0t: %s: expected %0h, got %0h", $realtime, what, want, got);
    endtask

    always @(posedge clk)
    begin : check_results
        i2cee_pkg::result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_cmds.size() == 0)
                flag_mismatch("transfer with nothing expected, command", 0, 32'(command));
            else
            begin
                want = expected_cmds.pop_front();
                if (command !== want.command)
                    flag_mismatch("command", 32'(want.command), 32'(command));
                if (tx_byte !== want.tx_byte)
                    flag_mismatch("tx_byte", 32'(want.tx_byte), 32'(tx_byte));
                if (done_res !== want.done_res)
                    flag_mismatch("done_res", 32'(want.done_res), 32'(done_res));
                if (error_code !== want.error_code)
                    flag_mismatch("error_code", 32'(want.error_code), 32'(error_code));
                if (read_byte !== want.read_byte)
                    flag_mismatch("read_byte", 32'(want.read_byte), 32'(read_byte));
            end
        end
    end

    initial
    begin : watchdog
        int unsigned quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------
    task automatic test_write_path();
        send_request(i2cee_pkg::ACT_WRITE, i2cee_pkg::CHIP_ONE, 16'hFFFF, 8'h00);
        send_event(i2cee_pkg::ST_START | 8'h07, 8'h00);
        send_event(i2cee_pkg::ST_SLAW_ACK, 8'hFF);
        send_event(i2cee_pkg::ST_DATA_TX_ACK | 8'h05, 8'h00);
        send_event(i2cee_pkg::ST_DATA_TX_ACK, 8'hFF);
        send_event(i2cee_pkg::ST_DATA_TX_ACK | 8'h02, 8'h00);
    endtask

    task automatic test_read_path();
        send_request(i2cee_pkg::ACT_READ, i2cee_pkg::CHIP_TWO, 16'h0000, 8'hFF);
        send_event(i2cee_pkg::ST_REP_START, 8'h00);
        send_event(i2cee_pkg::ST_SLAW_ACK | 8'h07, 8'h00);
        send_event(i2cee_pkg::ST_DATA_TX_ACK, 8'h00);
        send_event(i2cee_pkg::ST_DATA_TX_ACK, 8'h00);
        send_event(i2cee_pkg::ST_REP_START | 8'h01, 8'h00);
        send_event(i2cee_pkg::ST_SLAR_ACK, 8'h00);
        send_event(i2cee_pkg::ST_DATA_RX_NACK, 8'hFF);
    endtask

    // The chip NACKs its address while busy; a repeated start must also be
    // taken as a good start during polling.
    task automatic test_ack_polling();
        send_request(i2cee_pkg::ACT_WRITE, i2cee_pkg::CHIP_ONE, 16'h8001, 8'hFF);
        send_event(i2cee_pkg::ST_START, 8'h00);
        send_event(8'h20, 8'h00);
        send_event(i2cee_pkg::ST_REP_START, 8'h00);
        send_event(i2cee_pkg::ST_SLAW_ACK, 8'h00);
        send_event(8'h30, 8'h00);
    endtask

    task automatic test_ignored_and_bad();
        send_event(i2cee_pkg::ST_START, 8'h00);
        send_request(2'd3, i2cee_pkg::CHIP_ONE, 16'h1234, 8'h56);
        send_request(i2cee_pkg::ACT_WRITE, 2'd0, 16'hFFFF, 8'hFF);
        send_request(i2cee_pkg::ACT_READ, 2'd3, 16'h0000, 8'h00);
        send_request(i2cee_pkg::ACT_READ, i2cee_pkg::CHIP_ONE, 16'h5AA5, 8'h00);
        send_request(i2cee_pkg::ACT_WRITE, i2cee_pkg::CHIP_TWO, 16'h0000, 8'h00);
        send_request(2'd3, i2cee_pkg::CHIP_TWO, 16'h0000, 8'h00);
        send_event(8'h00, 8'h00);
    endtask

    task automatic test_pin_extremes();
        write_pins(i2cee_pkg::CFG_CHIP_ONE_PINS, 3'd0);
        write_pins(i2cee_pkg::CFG_CHIP_TWO_PINS, 3'd7);
        send_request(i2cee_pkg::ACT_READ, i2cee_pkg::CHIP_ONE, 16'h00FF, 8'h00);
        send_event(i2cee_pkg::ST_START, 8'h00);
        send_event(i2cee_pkg::ST_SLAW_ACK, 8'h00);
        send_event(i2cee_pkg::ST_DATA_TX_ACK, 8'h00);
        send_event(i2cee_pkg::ST_DATA_TX_ACK, 8'h00);
        send_event(i2cee_pkg::ST_REP_START, 8'h00);
        send_event(8'h48, 8'h00);
        send_request(i2cee_pkg::ACT_WRITE, i2cee_pkg::CHIP_TWO, 16'hFF00, 8'h81);
        send_event(i2cee_pkg::ST_START, 8'h00);
        send_event(8'hF8, 8'h00);
        write_pins(i2cee_pkg::CFG_CHIP_ONE_PINS, 3'd7);
        write_pins(i2cee_pkg::CFG_CHIP_TWO_PINS, 3'd0);
        send_request(i2cee_pkg::ACT_WRITE, i2cee_pkg::CHIP_ONE, 16'hAAAA, 8'h55);
        send_event(i2cee_pkg::ST_REP_START, 8'h00);
        send_event(8'hFF, 8'h00);
        send_request(i2cee_pkg::ACT_READ, i2cee_pkg::CHIP_TWO, 16'h5555, 8'hAA);
        send_event(i2cee_pkg::ST_START, 8'h00);
        send_event(i2cee_pkg::ST_SLAW_ACK, 8'h00);
        send_event(i2cee_pkg::ST_DATA_TX_ACK, 8'h00);
        send_event(i2cee_pkg::ST_DATA_TX_ACK, 8'h00);
        send_event(i2cee_pkg::ST_REP_START, 8'h00);
        send_event(i2cee_pkg::ST_SLAR_ACK, 8'h00);
        send_event(i2cee_pkg::ST_DATA_RX_NACK, 8'h3C);
    endtask

    // Status that lets the current step go on; the address phase sometimes
    // NACKs instead so that polling is exercised.
    function automatic logic [7:0] good_status(input i2cee_pkg::phase_t ph);
        logic [7:0] st;
        case (ph)
            i2cee_pkg::PH_START:
                st = $urandom_range(0, 1) ? i2cee_pkg::ST_START : i2cee_pkg::ST_REP_START;
            i2cee_pkg::PH_SLAW:
                st = ($urandom_range(0, 99) < 15) ? 8'($urandom) : i2cee_pkg::ST_SLAW_ACK;
            i2cee_pkg::PH_RESTART:
                st = i2cee_pkg::ST_REP_START;
            i2cee_pkg::PH_SLAR:
                st = i2cee_pkg::ST_SLAR_ACK;
            i2cee_pkg::PH_RX:
                st = i2cee_pkg::ST_DATA_RX_NACK;
            default:
                st = i2cee_pkg::ST_DATA_TX_ACK;
        endcase
        return st | 8'($urandom_range(0, 7));
    endfunction

    task automatic random_transaction();
        logic [1:0]  chip_no;
        int unsigned pick;
        if ($urandom_range(0, 9) == 0)
            chip_no = $urandom_range(0, 1) ? 2'd3 : 2'd0;
        else
            chip_no = $urandom_range(0, 1) ? i2cee_pkg::CHIP_TWO : i2cee_pkg::CHIP_ONE;
        send_request($urandom_range(0, 1) ? i2cee_pkg::ACT_READ : i2cee_pkg::ACT_WRITE,
                     chip_no, 16'($urandom), 8'($urandom));
        while (pred_phase != i2cee_pkg::PH_IDLE)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 4)
                send_request(2'($urandom), 2'($urandom), 16'($urandom), 8'($urandom));
            else if (pick < 10)
                send_event(8'($urandom), 8'($urandom));
            else
                send_event(good_status(pred_phase), 8'($urandom));
        end
    endtask

    task automatic random_noise();
        i2cee_pkg::item_t it;
        it = i2cee_pkg::item_t'(44'({$urandom, $urandom}));
        send_item(it);
    endtask

    task automatic run_random_until(input int unsigned target);
        while (answered_items < target)
        begin
            if ($urandom_range(0, 4) == 0)
                random_noise();
            else
                random_transaction();
        end
    endtask

    task automatic test_random_traffic();
        int unsigned target;
        target = answered_items;
        for (int p = 0; p < 8; p++)
        begin
            write_pins(i2cee_pkg::CFG_CHIP_ONE_PINS, 3'($urandom_range(0, 7)));
            write_pins(i2cee_pkg::CFG_CHIP_TWO_PINS, 3'($urandom_range(0, 7)));
            // The last phase runs with both sides streaming flat out.
            if (p == 7)
            begin
                sender_idles   = 1'b0;
                receiver_idles = 1'b0;
            end
            target += 90;
            if (p == 3)
            begin
                run_random_until(target - 50);
                settle();
            end
            run_random_until(target);
        end
    endtask

    initial
    begin
        pred_phase    = i2cee_pkg::PH_IDLE;
        pred_is_read  = 1'b0;
        pred_pins     = 3'd0;
        pred_address  = 16'd0;
        pred_data     = 8'd0;
        pred_pins_one = i2cee_pkg::CHIP_ONE_PINS_RESET;
        pred_pins_two = i2cee_pkg::CHIP_TWO_PINS_RESET;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_write_path();
        test_read_path();
        test_ack_polling();
        test_ignored_and_bad();
        test_pin_extremes();
        test_random_traffic();

        settle();
        if (mismatches == 0 && expected_cmds.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
